// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scheduler's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a synchronous active-low reset as the disable term.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("scheduler assertion failed");

// Condition that must never be seen on a clock edge out of reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    `ASSERT_CLK(label, clk, rstn, !(cond))

`endif

// ===== sv/ptrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrs_pkg
// Types and constants of the periodic task release scheduler.
// ----------------------------------------------------------------------------
package ptrs_pkg;

    localparam int TAG_W     = 16;
    localparam int CD_W      = 17;
    localparam int PER_W     = 16;
    localparam int PEND_W    = 16;
    localparam int LIMIT_W   = 16;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 4;
    localparam int REQ_W     = 2;
    localparam int MAX_RES   = 16;
    localparam int RES_CNT_W = 5;

    localparam logic [REQ_W-1:0] REQ_ADD      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DISPATCH = 2'd2;
    localparam logic [REQ_W-1:0] REQ_START    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_PER   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TICK       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_RELEASE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOTHING    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_STARTED    = 3'd7;

    localparam logic [LIMIT_W-1:0] TICK_LIMIT_RST = 16'd10;
    localparam logic [PEND_W-1:0]  PEND_MAX       = 16'hFFFF;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CD_W-1:0]  cd;
        logic [PER_W-1:0] period;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [TAG_W-1:0]    tag;
        logic [PEND_W-1:0]   pending;
        logic                overrun;
        logic                last;
    } res_t;

    typedef struct packed {
        logic push;
        logic fin;
        res_t res;
    } octl_t;

    typedef struct packed {
        logic held_vld;
        logic push_ok;
    } ostat_t;

endpackage

// ===== sv/ptrs_ram.sv =====
// ----------------------------------------------------------------------------
// ptrs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ptrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ptrs_seq.sv =====
// ----------------------------------------------------------------------------
// ptrs_seq
// Request sequencer: tick counter, free-slot walk for add, and the dispatch
// walk that reads, decrements and writes back each task table entry.
// ----------------------------------------------------------------------------
module ptrs_seq #(
    parameter int MAX_TASKS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [15:0]           s_task_tag,
    input  logic [15:0]           s_first_delay,
    input  logic [15:0]           s_period,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,
    input  ptrs_pkg::ostat_t      ostat,
    output ptrs_pkg::octl_t       octl
);

    localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int CD_W    = ptrs_pkg::CD_W;
    localparam int SLOT_W  = ptrs_pkg::SLOT_W;
    localparam int RCNT_W  = ptrs_pkg::RES_CNT_W;
    localparam int ENTRY_W = $bits(ptrs_pkg::entry_t);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_DSP  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [15:0]          limit_reg, limit_next;
    logic [15:0]          pend_reg, pend_next;
    logic                 ovr_reg, ovr_next;
    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [15:0]          tag_reg, tag_next;
    logic [15:0]          delay_reg, delay_next;
    logic [15:0]          per_reg, per_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 e_vld_reg, e_vld_next;
    logic [IDX_W-1:0]     e_idx_reg, e_idx_next;
    logic [RCNT_W-1:0]    rel_cnt_reg, rel_cnt_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    ptrs_pkg::entry_t     ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    ptrs_pkg::entry_t     ram_rdata;

    logic [15:0]          tick_cnt;
    logic [CD_W-1:0]      cd_dec;
    logic                 hit;
    logic                 rel;
    logic                 report;
    logic                 stall;
    ptrs_pkg::res_t       res;

    ptrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE) && !ostat.held_vld;
    assign tick_cnt = (pend_reg == ptrs_pkg::PEND_MAX) ? pend_reg : pend_reg + 16'd1;
    assign cd_dec   = ram_rdata.cd - CD_W'(1);
    assign hit      = e_vld_reg && valid_reg[e_idx_reg];
    assign rel      = hit && (cd_dec == '0);
    assign report   = rel && (rel_cnt_reg < RCNT_W'(ptrs_pkg::MAX_RES));
    assign stall    = report && !ostat.push_ok;

    always_comb begin
        state_next   = state_reg;
        limit_next   = cfg_we ? cfg_wdata : limit_reg;
        pend_next    = pend_reg;
        ovr_next     = ovr_reg;
        valid_next   = valid_reg;
        tag_next     = tag_reg;
        delay_next   = delay_reg;
        per_next     = per_reg;
        idx_next     = idx_reg;
        rd_idx_next  = rd_idx_reg;
        e_vld_next   = e_vld_reg;
        e_idx_next   = e_idx_reg;
        rel_cnt_next = rel_cnt_reg;

        ram_we       = 1'b0;
        ram_waddr    = e_idx_reg;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = rd_idx_reg[IDX_W-1:0];

        res          = '0;
        res.pending  = pend_reg;
        res.overrun  = ovr_reg;
        res.last     = 1'b1;
        octl.push    = 1'b0;
        octl.fin     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    case (s_req_type)
                        ptrs_pkg::REQ_ADD: begin
                            tag_next   = s_task_tag;
                            delay_next = s_first_delay;
                            per_next   = s_period;
                            idx_next   = '0;
                            state_next = S_ADD;
                        end
                        ptrs_pkg::REQ_TICK: begin
                            pend_next   = tick_cnt;
                            ovr_next    = ovr_reg || (tick_cnt > limit_reg);
                            res.status  = ptrs_pkg::ST_TICK;
                            res.pending = tick_cnt;
                            res.overrun = ovr_next;
                            octl.push   = 1'b1;
                        end
                        ptrs_pkg::REQ_DISPATCH: begin
                            if (pend_reg == '0) begin
                                res.status = ptrs_pkg::ST_NOTHING;
                                octl.push  = 1'b1;
                            end else begin
                                pend_next    = pend_reg - 16'd1;
                                rd_idx_next  = '0;
                                e_vld_next   = 1'b0;
                                rel_cnt_next = '0;
                                state_next   = S_DSP;
                            end
                        end
                        default: begin
                            pend_next   = '0;
                            ovr_next    = 1'b0;
                            res.status  = ptrs_pkg::ST_STARTED;
                            res.pending = '0;
                            res.overrun = 1'b0;
                            octl.push   = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (!valid_reg[idx_reg]) begin
                    if (per_reg == '0) begin
                        res.status = ptrs_pkg::ST_ZERO_PER;
                    end else begin
                        ram_we               = 1'b1;
                        ram_waddr            = idx_reg;
                        ram_wdata.tag        = tag_reg;
                        ram_wdata.cd         = CD_W'(delay_reg) + CD_W'(1);
                        ram_wdata.period     = per_reg;
                        valid_next[idx_reg]  = 1'b1;
                        res.status           = ptrs_pkg::ST_ADDED;
                        res.slot             = SLOT_W'(idx_reg);
                    end
                    octl.push  = 1'b1;
                    state_next = S_IDLE;
                end else if (idx_reg == IDX_W'(MAX_TASKS - 1)) begin
                    res.status = ptrs_pkg::ST_FULL;
                    octl.push  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DSP: begin
                if (!stall) begin
                    if (hit) begin
                        ram_we       = 1'b1;
                        ram_wdata.cd = rel ? CD_W'(ram_rdata.period) : cd_dec;
                    end
                    if (report) begin
                        res.status   = ptrs_pkg::ST_RELEASED;
                        res.slot     = SLOT_W'(e_idx_reg);
                        res.tag      = ram_rdata.tag;
                        res.last     = 1'b0;
                        octl.push    = 1'b1;
                        rel_cnt_next = rel_cnt_reg + RCNT_W'(1);
                    end
                    if (rd_idx_reg < CNT_W'(MAX_TASKS)) begin
                        ram_re      = 1'b1;
                        e_vld_next  = 1'b1;
                        e_idx_next  = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end else begin
                        e_vld_next = 1'b0;
                        if (!e_vld_reg) begin
                            if (ostat.held_vld) begin
                                octl.fin = 1'b1;
                            end else begin
                                res.status = ptrs_pkg::ST_NO_RELEASE;
                                octl.push  = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        octl.res = res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            limit_reg   <= ptrs_pkg::TICK_LIMIT_RST;
            pend_reg    <= '0;
            ovr_reg     <= 1'b0;
            valid_reg   <= '0;
            idx_reg     <= '0;
            rd_idx_reg  <= '0;
            e_vld_reg   <= 1'b0;
            e_idx_reg   <= '0;
            rel_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            pend_reg    <= pend_next;
            ovr_reg     <= ovr_next;
            valid_reg   <= valid_next;
            idx_reg     <= idx_next;
            rd_idx_reg  <= rd_idx_next;
            e_vld_reg   <= e_vld_next;
            e_idx_reg   <= e_idx_next;
            rel_cnt_reg <= rel_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg   <= tag_next;
        delay_reg <= delay_next;
        per_reg   <= per_next;
    end

endmodule

// ===== sv/ptrs_out.sv =====
// ----------------------------------------------------------------------------
// ptrs_out
// Result staging: a held result, released once the next one or the end of
// the request is known, and the output register of the result channel.
// ----------------------------------------------------------------------------
module ptrs_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  ptrs_pkg::octl_t  octl,
    output ptrs_pkg::ostat_t ostat,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_status,
    output logic [3:0]       m_slot,
    output logic [15:0]      m_task_tag_res,
    output logic [15:0]      m_pending_ticks,
    output logic             m_overrun,
    output logic             m_last
);

    logic           held_vld_reg, held_vld_next;
    ptrs_pkg::res_t held_reg, held_next;
    logic           m_vld_reg, m_vld_next;
    ptrs_pkg::res_t out_reg, out_next;
    logic           out_free;
    logic           move;

    assign out_free = !m_vld_reg || m_ready;
    assign move     = held_vld_reg && out_free && (held_reg.last || octl.push);

    assign ostat.held_vld = held_vld_reg;
    assign ostat.push_ok  = !held_vld_reg || out_free;

    always_comb begin
        held_vld_next = held_vld_reg;
        held_next     = held_reg;
        m_vld_next    = m_vld_reg;
        out_next      = out_reg;

        if (move) begin
            m_vld_next = 1'b1;
            out_next   = held_reg;
        end else if (m_ready) begin
            m_vld_next = 1'b0;
        end

        if (octl.push) begin
            held_vld_next = 1'b1;
            held_next     = octl.res;
        end else if (move) begin
            held_vld_next = 1'b0;
        end

        if (octl.fin) begin
            held_next.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_vld_reg <= 1'b0;
            m_vld_reg    <= 1'b0;
        end else begin
            held_vld_reg <= held_vld_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        out_reg  <= out_next;
    end

    assign m_valid         = m_vld_reg;
    assign m_status        = out_reg.status;
    assign m_slot          = out_reg.slot;
    assign m_task_tag_res  = out_reg.tag;
    assign m_pending_ticks = out_reg.pending;
    assign m_overrun       = out_reg.overrun;
    assign m_last          = out_reg.last;

endmodule

// ===== sv/periodic_task_release_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler_top
// Time-triggered periodic task table with add, tick, dispatch and start
// requests; dispatch releases every task whose countdown expires.
// ----------------------------------------------------------------------------
// Tick and start: the result goes to the held register, then the output register; no
// new request is accepted while a result is held. Add walks the valid bits one slot a
// cycle until it finds a free slot or reaches the last one. Dispatch walks the table
// RAM entry by entry and stalls while the result channel cannot take a release.
// Reset (aresetn low, synchronous) clears the valid bits, pending count and
// overrun flag and loads the tick limit with 10; the RAM needs no clearing.
module periodic_task_release_scheduler_top #(
    parameter int MAX_TASKS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_task_tag,
    input  logic [15:0] s_first_delay,
    input  logic [15:0] s_period,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_slot,
    output logic [15:0] m_task_tag_res,
    output logic [15:0] m_pending_ticks,
    output logic        m_overrun,
    output logic        m_last,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    ptrs_pkg::octl_t  octl;
    ptrs_pkg::ostat_t ostat;

    ptrs_seq #(
        .MAX_TASKS (MAX_TASKS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_task_tag    (s_task_tag),
        .s_first_delay (s_first_delay),
        .s_period      (s_period),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .ostat         (ostat),
        .octl          (octl)
    );

    ptrs_out u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .octl            (octl),
        .ostat           (ostat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot          (m_slot),
        .m_task_tag_res  (m_task_tag_res),
        .m_pending_ticks (m_pending_ticks),
        .m_overrun       (m_overrun),
        .m_last          (m_last)
    );

endmodule

// ===== sv/ptrs_checker.sv =====
// ----------------------------------------------------------------------------
// ptrs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptrs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [3:0]  m_slot,
    input logic [15:0] m_task_tag_res,
    input logic [15:0] m_pending_ticks,
    input logic        m_last
);

    // A stalled result keeps its contents.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot) && $stable(m_task_tag_res) && $stable(m_last))

    // No new request is taken while a dispatch still has releases to report.
    `ASSERT_NEVER(a_busy_release, aclk, aresetn, m_valid && !m_last && s_ready)

    // Only a release carries a task tag.
    `ASSERT_CLK(a_tag_release, aclk, aresetn, m_valid && (m_status != ptrs_pkg::ST_RELEASED) |-> (m_task_tag_res == 16'd0))

    // Every result other than a release is the single, final one of its request.
    `ASSERT_CLK(a_single_result, aclk, aresetn, m_valid && (m_status != ptrs_pkg::ST_RELEASED) |-> m_last)

    // A counted tick always leaves at least one tick pending.
    `ASSERT_CLK(a_tick_pending, aclk, aresetn, m_valid && (m_status == ptrs_pkg::ST_TICK) |-> (m_pending_ticks != 16'd0))

endmodule

bind periodic_task_release_scheduler_top ptrs_checker u_ptrs_checker (.*);
